// File: sv/satl_pkg.sv
// ----------------------------------------------------------------------------
// satl_pkg
// Types and constants shared by the set-associative tag lookup block.
// ----------------------------------------------------------------------------
package satl_pkg;

    localparam int SETS      = 16;
    localparam int SET_W     = 4;
    localparam int MAX_WAYS  = 8;
    localparam int WAY_W     = 3;
    localparam int WAY_CNT_W = 4;
    localparam int ADDR_W    = 32;
    localparam int TAG_W     = ADDR_W - SET_W;

    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 1'b0;
    localparam logic [WAY_CNT_W-1:0] WAYS_RESET      = 4'd8;

    typedef logic [WAY_CNT_W-1:0]               t_way_cnt;
    typedef logic [WAY_W-1:0]                   t_way;
    typedef logic [SET_W-1:0]                   t_set;
    typedef logic [TAG_W-1:0]                   t_tag;
    typedef logic [MAX_WAYS-1:0][TAG_W-1:0]     t_tag_row;
    typedef logic [MAX_WAYS-1:0]                t_valid_row;

    typedef enum logic {
        ST_IDLE,
        ST_COMPARE
    } t_state;

    typedef struct packed {
        logic lookup;   // transfer accepted: read the set
        logic commit;   // resolve hit/fill and load the result register
    } t_cmd;

endpackage

// File: sv/satl_ctrl.sv
// ----------------------------------------------------------------------------
// satl_ctrl
// Sequencer: accepts one address, then resolves it once the result register
// is free, and tracks the result register's valid flag.
// ----------------------------------------------------------------------------
module satl_ctrl
    import satl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.lookup = 1'b0;
        o_cmd.commit = 1'b0;
        o_in_stall   = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.lookup = 1'b1;
                    n_state      = ST_COMPARE;
                end
            end
            ST_COMPARE: begin
                // hold until the previous result has left
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_out_valid = o_cmd.commit | (r_out_valid & i_out_stall);
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: sv/satl_datapath.sv
// ----------------------------------------------------------------------------
// satl_datapath
// Tag memory, valid bits, per-set FIFO pointers, the parallel way compare,
// victim selection and the result register.
// ----------------------------------------------------------------------------
module satl_datapath
    import satl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [ADDR_W-1:0]   i_address,
    input  t_way_cnt            i_ways_in_use,
    output logic                o_is_hit,
    output logic [WAY_W-1:0]    o_way_used
);

    t_tag_row   mem_tag [SETS];
    t_valid_row r_valid [SETS];
    t_way       r_fifo  [SETS];

    t_set       r_set;
    t_tag       r_tag;
    t_tag_row   r_row_tag;
    t_valid_row r_row_valid;
    t_way       r_ptr;
    logic       r_is_hit;
    t_way       r_way_used;

    t_way_cnt   ways;
    logic       hit;
    t_way       hit_way;
    logic       have_free;
    t_way       free_way;
    t_way       victim;
    t_way_cnt   victim_inc;
    t_way       next_ptr;
    t_tag_row   fill_row;

    // register value 0 acts as one way, values above the maximum clamp
    always_comb begin
        if (i_ways_in_use == '0) begin
            ways = t_way_cnt'(1);
        end else if (i_ways_in_use > t_way_cnt'(MAX_WAYS)) begin
            ways = t_way_cnt'(MAX_WAYS);
        end else begin
            ways = i_ways_in_use;
        end
    end

    // read the set at transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_set       <= i_address[SET_W-1:0];
            r_tag       <= i_address[ADDR_W-1:SET_W];
            r_row_tag   <= mem_tag[i_address[SET_W-1:0]];
            r_row_valid <= r_valid[i_address[SET_W-1:0]];
            r_ptr       <= r_fifo[i_address[SET_W-1:0]];
        end
    end

    // lowest matching way wins; lowest free way is filled first
    always_comb begin
        hit       = 1'b0;
        hit_way   = '0;
        have_free = 1'b0;
        free_way  = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (t_way_cnt'(w) < ways) begin
                if (r_row_valid[w] && r_row_tag[w] == r_tag) begin
                    hit     = 1'b1;
                    hit_way = t_way'(w);
                end
                if (!r_row_valid[w]) begin
                    have_free = 1'b1;
                    free_way  = t_way'(w);
                end
            end
        end

        if (have_free) begin
            victim = free_way;
        end else if ({1'b0, r_ptr} >= ways) begin
            // stale pointer after the way count was lowered
            victim = '0;
        end else begin
            victim = r_ptr;
        end

        victim_inc = {1'b0, victim} + t_way_cnt'(1);
        next_ptr   = (victim_inc == ways) ? '0 : victim_inc[WAY_W-1:0];

        fill_row         = r_row_tag;
        fill_row[victim] = r_tag;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && !hit) begin
            mem_tag[r_set] <= fill_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SETS; s++) begin
                r_valid[s] <= '0;
                r_fifo[s]  <= '0;
            end
        end else if (i_cmd.commit && !hit) begin
            r_valid[r_set][victim] <= 1'b1;
            r_fifo[r_set]          <= next_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_is_hit   <= hit;
            r_way_used <= hit ? hit_way : victim;
        end
    end

    assign o_is_hit   = r_is_hit;
    assign o_way_used = r_way_used;

endmodule

// File: sv/set_assoc_cache_tag_lookup_core.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup_core
// Tag store of a 16-set, 8-way cache with FIFO replacement per set.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel carries one 32-bit address per transfer (i_in_valid,
//   o_in_stall). The low 4 bits pick the set, the upper 28 bits are the tag.
//   Output channel returns one result per address (o_out_valid, i_out_stall):
//   o_is_hit and o_way_used, the way that hit or the way just filled.
//   An address takes two steps: one reads the set's tag row, valid bits and
//   FIFO pointer from storage, one compares all ways, picks the victim and
//   writes the set back; the input stalls until that step is done.
//   The result sits in an output register; a new address is accepted while
//   it waits, but that address is not resolved until the result has left,
//   so a stalled receiver holds off the input after one address.
//   The APB register ways_in_use (address 0) sets the ways searched and
//   replaced; write it only while the block is idle.
//   Reset clears all valid bits and FIFO pointers at once, sets ways_in_use
//   to 8 and empties the output register.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lookup_core
    import satl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,

    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [ADDR_W-1:0]   i_address,

    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_is_hit,
    output logic [WAY_W-1:0]    o_way_used
);

    t_way_cnt r_ways_in_use;
    t_cmd     cmd;
    logic     reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1:2] == REG_WAYS_IN_USE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ways_in_use <= WAYS_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_ways_in_use <= pwdata[WAY_CNT_W-1:0];
        end
    end

    assign prdata = reg_sel ? {{(PDATA_W-WAY_CNT_W){1'b0}}, r_ways_in_use} : '0;

    satl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    satl_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_address     (i_address),
        .i_ways_in_use (r_ways_in_use),
        .o_is_hit      (o_is_hit),
        .o_way_used    (o_way_used)
    );

endmodule
